[src/lcte_pkg.sv]
// Package for the comet trail engine: payload types, state codes and shared constants.
`timescale 1ns / 1ps
package lcte_pkg;

  parameter int unsigned CfgIdxW = 8;
  parameter int unsigned CfgDataW = 8;
  parameter int unsigned AccW = 17;
  parameter int unsigned TickCntW = 7;
  parameter int unsigned TickNumW = 6;

  parameter logic [AccW-1:0] TickUs = 17'd2000;
  parameter logic [TickCntW-1:0] TicksPerStep = 7'd80;

  parameter logic [CfgIdxW-1:0] CfgColorRed = 8'd0;
  parameter logic [CfgIdxW-1:0] CfgColorGreen = 8'd1;
  parameter logic [CfgIdxW-1:0] CfgColorBlue = 8'd2;
  parameter logic [CfgIdxW-1:0] CfgBrightness = 8'd3;

  parameter logic [1:0] BrightFull = 2'd0;
  parameter logic [1:0] BrightEighth = 2'd1;
  parameter logic [1:0] BrightMax = 2'd2;

  parameter logic [0:0] ActAdvance = 1'b0;
  parameter logic [0:0] ActRestart = 1'b1;

  typedef struct packed {
    logic [0:0]  action;
    logic [15:0] elapsed_us;
  } in_t;

  typedef struct packed {
    logic [2:0] led_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_t;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StTick   = 4'b0010,
    StSweepR = 4'b0100,
    StSweepW = 4'b1000
  } state_e;

  // Saturating decrement of a level by a tick count.
  function automatic logic [7:0] sat_sub(input logic [7:0] lvl, input logic [TickNumW-1:0] n);
    logic [7:0] n8;
    n8 = {{(8 - TickNumW){1'b0}}, n};
    sat_sub = (lvl >= n8) ? (lvl - n8) : 8'd0;
  endfunction

  function automatic logic [7:0] scale(input logic [7:0] lvl, input logic [1:0] bright);
    case (bright)
      BrightFull:   scale = lvl;
      BrightEighth: scale = lvl >> 3;
      default:      scale = lvl >> 6;
    endcase
  endfunction

endpackage

[src/led_comet_trail_engine.sv]
// Comet trail engine: tick counter, trail memory sweep and scaled LED output.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid_i / in_stall_o  | lcte_pkg::in_t  (action, elapsed_us)
//   out      | out_valid_o / out_stall_i| lcte_pkg::out_t (one beat per LED)
//   cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A time item first counts its ticks in the tick state (T ticks, at most 33, one per
// cycle through the accumulator compare and subtract), then sweeps the trail memory
// once per LED (read, then modify and write back), held by any output stall.
// A restart item is done in the idle state; a time item with no tick skips the sweep.
// Reset is asynchronous; the trail memory reads as zero through per-entry valid flags
// that reset and restart clear at once, so no clearing pass is needed.
// A stalled output beat holds the sweep in its write step until the beat is taken.
`timescale 1ns / 1ps
module led_comet_trail_engine #(
  parameter int unsigned LED_COUNT = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lcte_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lcte_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcte_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lcte_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(LED_COUNT - 1);

  // configuration registers
  logic [7:0] color_red_q, color_green_q, color_blue_q;
  logic [1:0] bright_q;

  // animation state
  lcte_pkg::state_e               state_q, state_d;
  logic [lcte_pkg::AccW-1:0]      acc_q;
  logic [lcte_pkg::TickCntW-1:0]  cnt_q;
  logic [IdxW-1:0]                head_q;
  logic [lcte_pkg::TickNumW-1:0]  ticks_q;
  logic [lcte_pkg::TickNumW-1:0]  since_wr_q;
  logic                           wr_hit_q;
  logic [IdxW-1:0]                wr_pos_q;
  logic [IdxW-1:0]                k_q;

  // trail memory
  logic [23:0]          trail_mem [LED_COUNT];
  logic [LED_COUNT-1:0] vld_q;
  logic [23:0]          rd_data_q;
  logic                 rd_vld_q;

  // output register
  logic           out_valid_q;
  lcte_pkg::out_t out_q;

  logic                          accept;
  logic                          tick_now;
  logic [lcte_pkg::TickCntW-1:0] cnt_inc;
  logic                          emit;
  logic                          is_head;
  logic [7:0]                    base_r, base_g, base_b;
  logic [7:0]                    new_r, new_g, new_b;
  logic [IdxW+2:0]               k_wide;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != lcte_pkg::StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign tick_now = (acc_q >= lcte_pkg::TickUs);
  assign cnt_inc  = cnt_q + lcte_pkg::TickCntW'(1);
  assign emit     = (state_q == lcte_pkg::StSweepW) && (!out_valid_q || !out_stall_i);

  assign is_head = wr_hit_q && (k_q == wr_pos_q);
  assign base_r  = rd_vld_q ? rd_data_q[23:16] : 8'd0;
  assign base_g  = rd_vld_q ? rd_data_q[15:8] : 8'd0;
  assign base_b  = rd_vld_q ? rd_data_q[7:0] : 8'd0;
  assign new_r   = is_head ? lcte_pkg::sat_sub(color_red_q, since_wr_q)
                           : lcte_pkg::sat_sub(base_r, ticks_q);
  assign new_g   = is_head ? lcte_pkg::sat_sub(color_green_q, since_wr_q)
                           : lcte_pkg::sat_sub(base_g, ticks_q);
  assign new_b   = is_head ? lcte_pkg::sat_sub(color_blue_q, since_wr_q)
                           : lcte_pkg::sat_sub(base_b, ticks_q);
  assign k_wide  = {3'b000, k_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      lcte_pkg::StIdle: begin
        if (accept && in_data_i.action == lcte_pkg::ActAdvance) state_d = lcte_pkg::StTick;
      end
      lcte_pkg::StTick: begin
        if (!tick_now) begin
          state_d = (ticks_q == '0) ? lcte_pkg::StIdle : lcte_pkg::StSweepR;
        end
      end
      lcte_pkg::StSweepR: state_d = lcte_pkg::StSweepW;
      lcte_pkg::StSweepW: begin
        if (emit) state_d = (k_q == LastIdx) ? lcte_pkg::StIdle : lcte_pkg::StSweepR;
      end
      default: state_d = lcte_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_red_q   <= 8'd255;
      color_green_q <= 8'd0;
      color_blue_q  <= 8'd0;
      bright_q      <= lcte_pkg::BrightFull;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lcte_pkg::CfgColorRed:   color_red_q <= cfg_data_i;
        lcte_pkg::CfgColorGreen: color_green_q <= cfg_data_i;
        lcte_pkg::CfgColorBlue:  color_blue_q <= cfg_data_i;
        lcte_pkg::CfgBrightness: begin
          // clamp the unused code to the darkest setting
          bright_q <= (cfg_data_i[1:0] > lcte_pkg::BrightMax) ? lcte_pkg::BrightMax
                                                             : cfg_data_i[1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lcte_pkg::StIdle;
      acc_q      <= lcte_pkg::TickUs;
      cnt_q      <= lcte_pkg::TicksPerStep;
      head_q     <= '0;
      ticks_q    <= '0;
      since_wr_q <= '0;
      wr_hit_q   <= 1'b0;
      wr_pos_q   <= '0;
      k_q        <= '0;
      vld_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        lcte_pkg::StIdle: begin
          if (accept) begin
            if (in_data_i.action == lcte_pkg::ActRestart) begin
              acc_q  <= lcte_pkg::TickUs;
              cnt_q  <= lcte_pkg::TicksPerStep;
              head_q <= '0;
              vld_q  <= '0;
            end else begin
              acc_q <= acc_q + lcte_pkg::AccW'(in_data_i.elapsed_us);
            end
            ticks_q    <= '0;
            since_wr_q <= '0;
            wr_hit_q   <= 1'b0;
            k_q        <= '0;
          end
        end
        lcte_pkg::StTick: begin
          if (tick_now) begin
            acc_q   <= acc_q - lcte_pkg::TickUs;
            ticks_q <= ticks_q + lcte_pkg::TickNumW'(1);
            if (cnt_inc >= lcte_pkg::TicksPerStep) begin
              // head write on this tick; later ticks of the item still fade it
              cnt_q      <= '0;
              wr_hit_q   <= 1'b1;
              wr_pos_q   <= head_q;
              since_wr_q <= '0;
              head_q     <= (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
            end else begin
              cnt_q      <= cnt_inc;
              since_wr_q <= since_wr_q + lcte_pkg::TickNumW'(1);
            end
          end
        end
        lcte_pkg::StSweepW: begin
          if (emit) begin
            vld_q[k_q] <= 1'b1;
            k_q        <= (k_q == LastIdx) ? '0 : k_q + IdxW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // trail memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (state_q == lcte_pkg::StSweepR) begin
      rd_data_q <= trail_mem[k_q];
      rd_vld_q  <= vld_q[k_q];
    end
    if (emit) trail_mem[k_q] <= {new_r, new_g, new_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.led_index <= k_wide[2:0];
      out_q.out_red   <= lcte_pkg::scale(new_r, bright_q);
      out_q.out_green <= lcte_pkg::scale(new_g, bright_q);
      out_q.out_blue  <= lcte_pkg::scale(new_b, bright_q);
      out_q.frame_end <= (k_q == LastIdx);
    end
  end

  a_head_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastIdx && k_q <= LastIdx)
    else $error("head or sweep index outside the ring");

  a_acc_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcte_pkg::StSweepR) |-> (acc_q < lcte_pkg::TickUs))
    else $error("sweep started with a whole tick left in the accumulator");

  a_ticks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcte_pkg::StSweepR) |-> (ticks_q != '0 && ticks_q <= 6'd34))
    else $error("tick count out of range at sweep start");

  a_beat_from_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lcte_pkg::StSweepW))
    else $error("output beat raised outside the sweep write step");

  a_frame_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && k_q == LastIdx) |=> (state_q == lcte_pkg::StIdle && k_q == '0))
    else $error("sweep did not close after the last LED");

endmodule
